[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, removed when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

[hdl/dnr_pkg.sv]
// ----------------------------------------------------------------------------
// dnr_pkg
// shared types and character constants of the decimal number recogniser
// ----------------------------------------------------------------------------
package dnr_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EXP_U = 8'h45;
    localparam logic [7:0] CH_EXP_L = 8'h65;

    localparam int unsigned EXP_CNT_W = 3;
    localparam logic [EXP_CNT_W-1:0] EXP_MAX = 3'd4;

    typedef struct packed {
        logic valid;
        logic is_number;
    } t_result;

endpackage

[hdl/dnr_scan.sv]
// ----------------------------------------------------------------------------
// dnr_scan
// character scanner: phase, mantissa flag and exponent digit count, with the
// verdict raised on the end transfer
// ----------------------------------------------------------------------------
module dnr_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_char_code,
    input  logic            i_is_end,
    output dnr_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_EXP,
        PH_EXP_SIGN,
        PH_EXP_DIG,
        PH_FAIL
    } t_phase;

    t_phase r_phase, n_phase;
    logic   r_mant, n_mant;
    logic [dnr_pkg::EXP_CNT_W-1:0] r_exp_cnt, n_exp_cnt;

    logic c_digit, c_sign, c_blank, c_exp, c_point, verdict;

    assign c_digit = (i_char_code >= dnr_pkg::CH_ZERO) && (i_char_code <= dnr_pkg::CH_NINE);
    assign c_sign  = (i_char_code == dnr_pkg::CH_PLUS) || (i_char_code == dnr_pkg::CH_MINUS);
    assign c_blank = (i_char_code == dnr_pkg::CH_SPACE) || (i_char_code == dnr_pkg::CH_TAB);
    assign c_exp   = (i_char_code == dnr_pkg::CH_EXP_U) || (i_char_code == dnr_pkg::CH_EXP_L);
    assign c_point = (i_char_code == dnr_pkg::CH_POINT);

    assign verdict = (((r_phase == PH_INT) || (r_phase == PH_FRAC)) && r_mant) ||
                     ((r_phase == PH_EXP_DIG) && (r_exp_cnt != '0) &&
                      (r_exp_cnt < dnr_pkg::EXP_MAX));

    always_comb begin
        n_phase   = PH_FAIL;
        n_mant    = r_mant;
        n_exp_cnt = r_exp_cnt;
        unique case (r_phase)
            PH_BLANK: begin
                priority if (c_blank) begin
                    n_phase = PH_BLANK;
                end else if (c_sign) begin
                    n_phase = PH_SIGN;
                end else if (c_digit) begin
                    n_mant  = 1'b1;
                    n_phase = PH_INT;
                end else if (c_point) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_SIGN: begin
                priority if (c_digit) begin
                    n_mant  = 1'b1;
                    n_phase = PH_INT;
                end else if (c_point) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_INT, PH_FRAC: begin
                priority if (c_digit) begin
                    n_mant  = 1'b1;
                    n_phase = r_phase;
                end else if ((r_phase == PH_INT) && c_point) begin
                    n_phase = PH_FRAC;
                end else if (c_exp && r_mant) begin
                    n_phase = PH_EXP;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_EXP: begin
                priority if (c_sign) begin
                    n_phase = PH_EXP_SIGN;
                end else if (c_digit) begin
                    n_exp_cnt = dnr_pkg::EXP_CNT_W'(1);
                    n_phase   = PH_EXP_DIG;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_EXP_SIGN: begin
                if (c_digit) begin
                    n_exp_cnt = dnr_pkg::EXP_CNT_W'(1);
                    n_phase   = PH_EXP_DIG;
                end
            end
            PH_EXP_DIG: begin
                if (c_digit) begin
                    if (r_exp_cnt < dnr_pkg::EXP_MAX) begin
                        n_exp_cnt = r_exp_cnt + dnr_pkg::EXP_CNT_W'(1);
                    end
                    n_phase = PH_EXP_DIG;
                end
            end
            PH_FAIL: begin
                n_phase = PH_FAIL;
            end
            default: begin
                n_phase = PH_FAIL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_BLANK;
            r_mant    <= 1'b0;
            r_exp_cnt <= '0;
        end else if (i_take) begin
            if (i_is_end) begin
                r_phase   <= PH_BLANK;
                r_mant    <= 1'b0;
                r_exp_cnt <= '0;
            end else begin
                r_phase   <= n_phase;
                r_mant    <= n_mant;
                r_exp_cnt <= n_exp_cnt;
            end
        end
    end

    assign o_result.valid     = i_take && i_is_end;
    assign o_result.is_number = verdict;

endmodule

[hdl/dnr_out_buf.sv]
// ----------------------------------------------------------------------------
// dnr_out_buf
// result register with skid stage, stall towards the scanner is registered
// ----------------------------------------------------------------------------
module dnr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dnr_pkg::t_result i_result,
    output logic             o_full,
    output logic             o_valid,
    output logic             o_is_number,
    input  logic             i_stall
);

    logic r_main_valid, r_main_num;
    logic r_skid_valid, r_skid_num;
    logic pop;

    assign pop = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= i_result.valid;
                end
            end else if (!r_main_valid) begin
                r_main_valid <= i_result.valid;
            end else if (i_result.valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_main_valid) begin
            r_main_num <= r_skid_valid ? r_skid_num : i_result.is_number;
        end
        if (!r_skid_valid) begin
            r_skid_num <= i_result.is_number;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_valid     = r_main_valid;
    assign o_is_number = r_main_num;

endmodule

[hdl/decimal_number_recognizer_unit.sv]
// ----------------------------------------------------------------------------
// decimal_number_recognizer_unit
// checks a character string for a decimal number with optional exponent
//
//   channel  valid    stall    payload
//   input    i_valid  o_stall  i_char_code, i_is_end
//   output   o_valid  i_stall  o_is_number
//
// one character per cycle while o_stall is low; the scanner state updates at the transfer itself
// an end transfer's verdict is registered in the result register, or in the skid entry while that register is held
// a two-entry result buffer (register plus skid) keeps input flowing while
// a result waits; o_stall rises only when both entries are held
// synchronous active-low reset returns the scanner to leading blanks
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_number_recognizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_is_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_number
);

    logic             take;
    dnr_pkg::t_result result;

    assign take = i_valid && !o_stall;

    dnr_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_code (i_char_code),
        .i_is_end    (i_is_end),
        .o_result    (result)
    );

    dnr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_full      (o_stall),
        .o_valid     (o_valid),
        .o_is_number (o_is_number),
        .i_stall     (i_stall)
    );

    // skid entry only ever holds a result behind the main one
    `ASSERT_CLK(a_skid_behind_main, i_clk, i_rst_n, o_stall |-> o_valid, "skid full, main empty")

    // an end transfer always leaves a result waiting
    `ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, take && i_is_end, o_valid, "verdict lost")

    // the buffer fills only while the output is stalled
    `ASSERT_CLK(a_fill_on_stall, i_clk, i_rst_n, ($rose(o_stall) && $past(i_rst_n)) |-> $past(o_valid && i_stall), "buffer filled without stall")

endmodule

[verif/tb_decimal_number_recognizer_unit.sv]
// ----------------------------------------------------------------------------
// tb_decimal_number_recognizer_unit
// self-checking bench for the decimal number recogniser
// directed corner-case strings, then random numbers, broken strings and noise
// random idling on both channels, one long output hold, scoreboard checks
// ----------------------------------------------------------------------------
module tb_decimal_number_recognizer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_SPACE = dnr_pkg::CH_SPACE;
    localparam logic [7:0] CH_TAB   = dnr_pkg::CH_TAB;
    localparam logic [7:0] CH_PLUS  = dnr_pkg::CH_PLUS;
    localparam logic [7:0] CH_MINUS = dnr_pkg::CH_MINUS;
    localparam logic [7:0] CH_POINT = dnr_pkg::CH_POINT;
    localparam logic [7:0] CH_ZERO  = dnr_pkg::CH_ZERO;
    localparam logic [7:0] CH_NINE  = dnr_pkg::CH_NINE;
    localparam logic [7:0] CH_EXP_U = dnr_pkg::CH_EXP_U;
    localparam logic [7:0] CH_EXP_L = dnr_pkg::CH_EXP_L;

    localparam int unsigned EXP_CNT_W = dnr_pkg::EXP_CNT_W;
    localparam logic [EXP_CNT_W-1:0] EXP_MAX = dnr_pkg::EXP_MAX;

    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned LONG_HOLD    = 300;

    typedef enum logic [2:0] {
        SCAN_BLANK,
        SCAN_SIGN,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_EXP,
        SCAN_EXP_SIGN,
        SCAN_EXP_DIG,
        SCAN_FAIL
    } t_scan_phase;

    class t_number_scoreboard;
        t_scan_phase             phase;
        bit                      mantissa_seen;
        bit [EXP_CNT_W-1:0]      exponent_count;
        bit                      verdict_q[$];
        int                      errors;
        int                      verdicts_checked;
        int                      numbers_seen;

        function new();
            reset_scan();
            errors           = 0;
            verdicts_checked = 0;
            numbers_seen     = 0;
        endfunction

        function void reset_scan();
            phase          = SCAN_BLANK;
            mantissa_seen  = 1'b0;
            exponent_count = '0;
        endfunction

        function void note_input(logic [7:0] c, logic last);
            t_scan_phase next_phase;
            bit          digit;
            bit          sign;
            bit          blank;
            bit          expo;
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            sign  = (c == CH_PLUS) || (c == CH_MINUS);
            blank = (c == CH_SPACE) || (c == CH_TAB);
            expo  = (c == CH_EXP_U) || (c == CH_EXP_L);
            if (last) begin
                verdict_q.push_back(
                    (((phase == SCAN_INT) || (phase == SCAN_FRAC)) && mantissa_seen) ||
                    ((phase == SCAN_EXP_DIG) && (exponent_count >= 1) &&
                     (exponent_count < EXP_MAX)));
                reset_scan();
                return;
            end
            next_phase = SCAN_FAIL;
            case (phase)
                SCAN_BLANK: begin
                    if (blank) next_phase = SCAN_BLANK;
                    else if (sign) next_phase = SCAN_SIGN;
                    else if (digit) begin
                        mantissa_seen = 1'b1;
                        next_phase    = SCAN_INT;
                    end else if (c == CH_POINT) next_phase = SCAN_FRAC;
                end
                SCAN_SIGN: begin
                    if (digit) begin
                        mantissa_seen = 1'b1;
                        next_phase    = SCAN_INT;
                    end else if (c == CH_POINT) next_phase = SCAN_FRAC;
                end
                SCAN_INT, SCAN_FRAC: begin
                    if (digit) begin
                        mantissa_seen = 1'b1;
                        next_phase    = phase;
                    end else if ((phase == SCAN_INT) && (c == CH_POINT)) begin
                        next_phase = SCAN_FRAC;
                    end else if (expo && mantissa_seen) next_phase = SCAN_EXP;
                end
                SCAN_EXP: begin
                    if (sign) next_phase = SCAN_EXP_SIGN;
                    else if (digit) begin
                        exponent_count = EXP_CNT_W'(1);
                        next_phase     = SCAN_EXP_DIG;
                    end
                end
                SCAN_EXP_SIGN: begin
                    if (digit) begin
                        exponent_count = EXP_CNT_W'(1);
                        next_phase     = SCAN_EXP_DIG;
                    end
                end
                SCAN_EXP_DIG: begin
                    if (digit) begin
                        if (exponent_count < EXP_MAX)
                            exponent_count = exponent_count + EXP_CNT_W'(1);
                        next_phase = SCAN_EXP_DIG;
                    end
                end
                default: next_phase = SCAN_FAIL;
            endcase
            phase = next_phase;
        endfunction

        function void check_result(logic actual);
            bit expected_v;
            if (verdict_q.size() == 0) begin
                $error("is_number: result with no verdict pending, actual %0d", actual);
                errors++;
                return;
            end
            expected_v = verdict_q.pop_front();
            verdicts_checked++;
            if (expected_v) numbers_seen++;
            if (actual !== expected_v) begin
                $error("is_number mismatch: expected %0d, actual %0d", expected_v, actual);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_char_code;
    logic       i_is_end;
    logic       o_valid;
    logic       i_stall;
    logic       o_is_number;

    t_number_scoreboard sb;
    int unsigned        chars_sent;
    int unsigned        strings_sent;
    int unsigned        results_taken;
    bit                 no_idle;
    bit                 hold_done;

    decimal_number_recognizer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_is_end    (i_is_end),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_is_number (o_is_number)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_item(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_is_end    <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(c, last);
        if (last) strings_sent++;
        else chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input logic [7:0] end_code);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
        send_item(end_code, 1'b1);
    endtask

    task automatic take_results();
        int unsigned gap;
        forever begin
            if (!hold_done && (results_taken == 40)) begin
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            sb.check_result(o_is_number);
            results_taken++;
            @(negedge i_clk);
        end
    endtask

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("tb_decimal_number_recognizer_unit: FAIL");
        $finish;
    end

    initial begin
        logic [7:0]  text[$];
        int unsigned kind;
        int unsigned n;
        int unsigned int_digits;
        int unsigned frac_digits;
        bit          has_point;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_char_code   = 8'h00;
        i_is_end      = 1'b0;
        no_idle       = 1'b0;
        hold_done     = 1'b0;
        chars_sent    = 0;
        strings_sent  = 0;
        results_taken = 0;
        sb            = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        fork
            take_results();
        join_none

        // corner cases
        send_text("", 8'hFF);
        send_text(" \t", 8'h00);
        send_text(".", 8'h00);
        send_text("e", 8'h00);
        send_text("1E", 8'h00);
        send_text("1e-", 8'h00);
        send_text("1e1234", 8'h00);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        send_text(" 1 ", 8'h00);
        send_text("+.5", 8'h00);

        while (chars_sent + strings_sent < RANDOM_ITEMS + 32) begin
            text.delete();
            kind    = $urandom_range(0, 9);
            no_idle = (strings_sent % 40) >= 33;
            if (kind < 7) begin
                n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
                repeat (n) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                if ($urandom_range(0, 1)) text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                int_digits  = $urandom_range(0, 4);
                has_point   = $urandom_range(0, 2) == 0;
                frac_digits = has_point ? $urandom_range(0, 3) : 0;
                if ((int_digits == 0) && (frac_digits == 0) && ($urandom_range(0, 7) != 0))
                    int_digits = 1;
                repeat (int_digits) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                if (has_point) text.push_back(CH_POINT);
                repeat (frac_digits) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 1)) begin
                    text.push_back($urandom_range(0, 1) ? CH_EXP_U : CH_EXP_L);
                    if ($urandom_range(0, 1))
                        text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    n = $urandom_range(0, 4) == 0 ? $urandom_range(0, 5) : $urandom_range(1, 3);
                    repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                // broken number: one character replaced or appended
                if ((kind == 6) && (text.size() > 0))
                    text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
                else if (kind == 5)
                    text.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(0, 6);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                        1: text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                        2: text.push_back($urandom_range(0, 1) ? CH_EXP_U : CH_EXP_L);
                        3: text.push_back($urandom_range(0, 1) ? CH_POINT : CH_SPACE);
                        default: text.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            foreach (text[i]) send_item(text[i], 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d strings of %0d characters in all, %0d verdicts checked",
                 strings_sent, chars_sent, sb.verdicts_checked);
        $display("of which %0d were numbers, with one long output hold and idle-free stretches",
                 sb.numbers_seen);
        if ((sb.errors == 0) && (sb.verdict_q.size() == 0)) begin
            $display("tb_decimal_number_recognizer_unit: PASS");
        end else begin
            $display("tb_decimal_number_recognizer_unit: FAIL");
        end
        $finish;
    end

endmodule
